// ===== rtl/jse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants for the JSON string value extractor.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam int MAX_KEY_LEN_DEF = 16;
	localparam int DEPTH_BITS_DEF  = 16;
	localparam int KEY_REG_W       = 64;
	localparam int MAX_RES         = 7;
	localparam int RES_CNT_W       = 3;

	localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

	localparam logic [2:0] PH_SCAN    = 3'd0;
	localparam logic [2:0] PH_KEY     = 3'd1;
	localparam logic [2:0] PH_COLON   = 3'd2;
	localparam logic [2:0] PH_WAITVAL = 3'd3;
	localparam logic [2:0] PH_VALUE   = 3'd4;
	localparam logic [2:0] PH_HEX     = 3'd5;
	localparam logic [2:0] PH_OK      = 3'd6;
	localparam logic [2:0] PH_NOSTR   = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOTFND  = 2'd1;
	localparam logic [1:0] ST_NOTSTR  = 2'd2;
	localparam logic [1:0] ST_UNTERM  = 2'd3;

	// one result item
	typedef struct packed {
		logic       kind;
		logic [7:0] vbyte;
		logic [1:0] status;
		logic       last;
	} res_t;

	// results caused by one body byte
	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;
		res_t [MAX_RES-1:0]   res;
	} res_grp_t;

	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= "0" && b <= "9") v = {1'b0, b[3:0]};
		else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
			v = {1'b0, b[3:0] + 4'd9};
		return v;
	endfunction

	function automatic res_t val_res(input logic [7:0] b);
		res_t r;
		r.kind = 1'b0; r.vbyte = b; r.status = ST_OK; r.last = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/jse_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jse_parser
// Per-byte parse state update; produces the result group of one byte.
// ----------------------------------------------------------------------------
module jse_parser #(
	parameter int MAX_KEY_LEN = jse_pkg::MAX_KEY_LEN_DEF,
	parameter int DEPTH_BITS  = jse_pkg::DEPTH_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire  [7:0]                       b,
	input  wire                              blast,
	input  wire  [jse_pkg::KEY_REG_W-1:0]    key_low,
	input  wire  [jse_pkg::KEY_REG_W-1:0]    key_high,
	input  wire  [4:0]                       key_len,
	output jse_pkg::res_grp_t                grp
);
	localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic signed [DEPTH_BITS-1:0] ONE  = DEPTH_BITS'(1);

	logic signed [DEPTH_BITS-1:0] depth_q, depth_d;
	logic                         instr_q, instr_d, esc_q, esc_d, fin_q, fin_d;
	logic [2:0]                   ph_q, ph_d;
	logic [4:0]                   kcnt_q, kcnt_d;
	logic [23:0]                  hex_q, hex_d;
	logic [1:0]                   hcnt_q, hcnt_d;

	logic [127:0] key_all;
	logic [4:0]   len_eff;
	logic [7:0]   kbyte;
	logic         do_scan, is_sp;
	logic [4:0]   hv0, hv1, hv2, hvb;
	logic [15:0]  cp;
	jse_pkg::res_grp_t g;

	assign key_all = {key_high, key_low};
	assign len_eff = (key_len > 5'(MAX_KEY_LEN)) ? 5'(MAX_KEY_LEN) : key_len;
	assign kbyte   = key_all[kcnt_q[3:0]*8 +: 8];
	assign is_sp   = (b == " ") || (b >= 8'd9 && b <= 8'd13);
	assign hv0     = jse_pkg::hex_val(hex_q[7:0]);
	assign hv1     = jse_pkg::hex_val(hex_q[15:8]);
	assign hv2     = jse_pkg::hex_val(hex_q[23:16]);
	assign hvb     = jse_pkg::hex_val(b);
	assign cp      = {hv0[3:0], hv1[3:0], hv2[3:0], hvb[3:0]};

	always_comb begin
		depth_d = depth_q; instr_d = instr_q; esc_d = esc_q; fin_d = fin_q;
		ph_d = ph_q; kcnt_d = kcnt_q; hex_d = hex_q; hcnt_d = hcnt_q;
		g = '0;
		do_scan = 1'b0;
		if (!fin_q) begin
			case (ph_q)
				jse_pkg::PH_SCAN: do_scan = 1'b1;
				jse_pkg::PH_KEY: begin
					if (kcnt_q < len_eff && b != "\"" && b != "\\" && b == kbyte) begin
						kcnt_d = kcnt_q + 5'd1;
					end else if (kcnt_q == len_eff && b == "\"") begin
						instr_d = 1'b0; ph_d = jse_pkg::PH_COLON; kcnt_d = '0;
					end else begin
						ph_d = jse_pkg::PH_SCAN; kcnt_d = '0; do_scan = 1'b1;
					end
				end
				jse_pkg::PH_COLON: begin
					if (b == ":") ph_d = jse_pkg::PH_WAITVAL;
					else if (!is_sp) begin
						ph_d = jse_pkg::PH_SCAN; do_scan = 1'b1;
					end
				end
				jse_pkg::PH_WAITVAL: begin
					if (b == "\"") begin
						ph_d = jse_pkg::PH_VALUE; esc_d = 1'b0;
					end else if (!is_sp) begin
						ph_d = jse_pkg::PH_NOSTR; fin_d = 1'b1;
					end
				end
				jse_pkg::PH_VALUE: begin
					if (esc_q) begin
						esc_d = 1'b0;
						g.cnt = 3'd1;
						case (b)
							"\"": g.res[0] = jse_pkg::val_res(8'h22);
							"\\": g.res[0] = jse_pkg::val_res(8'h5C);
							"n":  g.res[0] = jse_pkg::val_res(8'h0A);
							"t":  g.res[0] = jse_pkg::val_res(8'h09);
							"r":  g.res[0] = jse_pkg::val_res(8'h0D);
							"b":  g.res[0] = jse_pkg::val_res(8'h08);
							"f":  g.res[0] = jse_pkg::val_res(8'h0C);
							"u": begin
								g.cnt = 3'd0; ph_d = jse_pkg::PH_HEX; hcnt_d = '0; hex_d = '0;
							end
							default: begin
								g.cnt = 3'd2;
								g.res[0] = jse_pkg::val_res(8'h5C);
								g.res[1] = jse_pkg::val_res(b);
							end
						endcase
					end else if (b == "\"") begin
						ph_d = jse_pkg::PH_OK; fin_d = 1'b1;
					end else if (b == "\\") begin
						esc_d = 1'b1;
					end else begin
						g.cnt = 3'd1; g.res[0] = jse_pkg::val_res(b);
					end
				end
				jse_pkg::PH_HEX: begin
					g.res[0] = jse_pkg::val_res(8'h5C);
					g.res[1] = jse_pkg::val_res("u");
					g.res[2] = jse_pkg::val_res(hex_q[7:0]);
					g.res[3] = jse_pkg::val_res(hex_q[15:8]);
					g.res[4] = jse_pkg::val_res(hex_q[23:16]);
					if (hvb[4]) begin
						// not a hex digit: flush held bytes, then handle b as in PH_VALUE
						ph_d = jse_pkg::PH_VALUE; hcnt_d = '0; hex_d = '0;
						g.cnt = 3'd2 + {1'b0, hcnt_q};
						if (b == "\"") begin
							ph_d = jse_pkg::PH_OK; fin_d = 1'b1;
						end else if (b == "\\") begin
							esc_d = 1'b1;
						end else begin
							g.res[g.cnt] = jse_pkg::val_res(b);
							g.cnt = g.cnt + 3'd1;
						end
					end else if (hcnt_q != 2'd3) begin
						hex_d[hcnt_q*8 +: 8] = b;
						hcnt_d = hcnt_q + 2'd1;
					end else begin
						ph_d = jse_pkg::PH_VALUE; hcnt_d = '0; hex_d = '0;
						if (cp < 16'h0080) begin
							g.cnt = 3'd1; g.res[0] = jse_pkg::val_res(cp[7:0]);
						end else begin
							g.cnt = 3'd6; g.res[5] = jse_pkg::val_res(b);
						end
					end
				end
				default: ;
			endcase
		end
		if (do_scan) begin
			if (instr_q) begin
				if (esc_q) esc_d = 1'b0;
				else if (b == "\\") esc_d = 1'b1;
				else if (b == "\"") instr_d = 1'b0;
			end else if (b == "\"") begin
				instr_d = 1'b1;
				if (depth_q == ONE) begin
					ph_d = jse_pkg::PH_KEY; kcnt_d = '0;
				end
			end else if (b == "{" || b == "[") begin
				if (depth_q < DMAX) depth_d = depth_q + ONE;
			end else if (b == "}" || b == "]") begin
				if (depth_q > DMIN) depth_d = depth_q - ONE;
			end
		end
		if (blast) begin
			g.res[g.cnt].kind = 1'b1;
			g.res[g.cnt].vbyte = '0;
			g.res[g.cnt].last = 1'b1;
			case (ph_d)
				jse_pkg::PH_OK:      g.res[g.cnt].status = jse_pkg::ST_OK;
				jse_pkg::PH_NOSTR,
				jse_pkg::PH_WAITVAL: g.res[g.cnt].status = jse_pkg::ST_NOTSTR;
				jse_pkg::PH_VALUE,
				jse_pkg::PH_HEX:     g.res[g.cnt].status = jse_pkg::ST_UNTERM;
				default:             g.res[g.cnt].status = jse_pkg::ST_NOTFND;
			endcase
			g.cnt = g.cnt + 3'd1;
			depth_d = '0; instr_d = 1'b0; esc_d = 1'b0; ph_d = jse_pkg::PH_SCAN;
			kcnt_d = '0; hex_d = '0; hcnt_d = '0; fin_d = 1'b0;
		end
	end

	assign grp = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0; instr_q <= 1'b0; esc_q <= 1'b0; fin_q <= 1'b0;
			ph_q <= jse_pkg::PH_SCAN; kcnt_q <= '0; hex_q <= '0; hcnt_q <= '0;
		end else if (en) begin
			depth_q <= depth_d; instr_q <= instr_d; esc_q <= esc_d; fin_q <= fin_d;
			ph_q <= ph_d; kcnt_q <= kcnt_d; hex_q <= hex_d; hcnt_q <= hcnt_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/jse_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jse_outbuf
// Holds the result group of one byte and drains it one item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module jse_outbuf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  wire jse_pkg::res_grp_t grp,
	output logic                free,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output jse_pkg::res_t       item
);
	jse_pkg::res_grp_t            grp_s1;
	logic [jse_pkg::RES_CNT_W-1:0] idx_q;
	logic                         done;

	assign m_tvalid = (idx_q != grp_s1.cnt);
	assign item     = grp_s1.res[idx_q];
	assign done     = !m_tvalid || (m_tready && idx_q + 3'd1 == grp_s1.cnt);
	assign free     = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_s1 <= '0;
			idx_q <= '0;
		end else if (load) begin
			grp_s1 <= grp;
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/json_top_level_string_extractor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_top_level_string_extractor
// Pulls one top-level string value out of a JSON body, streamed per byte.
// ----------------------------------------------------------------------------
// channel | dir | tdata                    | tuser       | tlast
// s_axis  | in  | body_byte[7:0]           | -           | body_last
// m_axis  | out | value_byte[7:0],status   | result_kind | result_last
// cfg     | in  | wr_en, wr_index, wr_data (key low, key high, key length)
// One byte per cycle unless stalled: while the result buffer drains a
// byte's results (up to 7), s_tready stays low until the last is taken.
// Parse state updates at the byte accept; results leave from a register.
// Reset clears parse state, key registers and the result buffer.
// ----------------------------------------------------------------------------
module json_top_level_string_extractor #(
	parameter int MAX_KEY_LEN = jse_pkg::MAX_KEY_LEN_DEF,
	parameter int DEPTH_BITS  = jse_pkg::DEPTH_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // body_byte
	input  wire         s_tlast,   // body_last
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // value_byte[7:0], status[9:8], zero fill
	output logic        m_tuser,   // result_kind
	output logic        m_tlast,   // result_last
	input  wire         wr_en,
	input  wire  [1:0]  wr_index,
	input  wire  [63:0] wr_data
);
	logic [63:0] key_low_q, key_high_q;
	logic [4:0]  key_len_q;
	logic        acc;
	jse_pkg::res_grp_t grp;
	jse_pkg::res_t     item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0; key_high_q <= '0; key_len_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				jse_pkg::CFG_KEY_LOW:  key_low_q  <= wr_data;
				jse_pkg::CFG_KEY_HIGH: key_high_q <= wr_data;
				jse_pkg::CFG_KEY_LEN:  key_len_q  <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	assign acc = s_tvalid && s_tready;

	jse_parser #(.MAX_KEY_LEN(MAX_KEY_LEN), .DEPTH_BITS(DEPTH_BITS)) u_parser (
		.clk(clk), .arst_n(arst_n), .en(acc), .b(s_tdata), .blast(s_tlast),
		.key_low(key_low_q), .key_high(key_high_q), .key_len(key_len_q), .grp(grp)
	);

	jse_outbuf u_outbuf (
		.clk(clk), .arst_n(arst_n), .load(acc), .grp(grp), .free(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .item(item)
	);

	assign m_tdata = {6'd0, item.status, item.vbyte};
	assign m_tuser = item.kind;
	assign m_tlast = item.last;
endmodule
`default_nettype wire
